// ----- design/gcat_pkg.sv -----
`default_nettype none
package gcat_pkg;

   localparam int CLAIM_ENTRIES = 16;
   localparam int AUTH_ENTRIES  = 16;
   localparam int HANDLE_SLOTS  = 16;
   localparam int GATE_BITS     = 11;

   localparam int OP_W      = 3;
   localparam int NONCE_W   = 64;
   localparam int GATE_W    = 11;
   localparam int HANDLE_W  = 4;
   localparam int STATUS_W  = 3;
   localparam int ACTIVE_W  = 5;
   localparam int REFS_W    = 5;

   localparam int CIDX_W = $clog2(CLAIM_ENTRIES);
   localparam int CCNT_W = $clog2(CLAIM_ENTRIES + 1);
   localparam int AIDX_W = $clog2(AUTH_ENTRIES);
   localparam int ACNT_W = $clog2(AUTH_ENTRIES + 1);
   localparam int SIDX_W = $clog2(HANDLE_SLOTS);

   localparam logic [GATE_W-1:0] GMASK = GATE_W'((64'(1) << GATE_BITS) - 64'(1));
   localparam logic [REFS_W-1:0] REFS_MAX = '1;
   localparam logic [GATE_W-1:0] VMASK_RESET = '1;

   typedef enum logic [OP_W-1:0] {
      OP_CHECK     = 3'd0,
      OP_CLAIM     = 3'd1,
      OP_RELEASE   = 3'd2,
      OP_MINT      = 3'd3,
      OP_AUTHORIZE = 3'd4,
      OP_REVOKE    = 3'd5,
      OP_RSVD_6    = 3'd6,
      OP_RSVD_7    = 3'd7
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 3'd0,
      ST_DENIED  = 3'd1,
      ST_INVALID = 3'd2,
      ST_NOID    = 3'd3,
      ST_UNSUP   = 3'd4,
      ST_FULL    = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CLM_RD,
      S_CLM_EV,
      S_AUTH_RD,
      S_AUTH_EV,
      S_SLOT_RD,
      S_SLOT_EV,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [OP_W-1:0]     operation;
      logic [NONCE_W-1:0]  requester_id;
      logic [GATE_W-1:0]   gates;
      logic [HANDLE_W-1:0] handle;
      logic [HANDLE_W-1:0] token_handle;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ACTIVE_W-1:0] claims_active;
   } rsp_type;

   typedef struct packed {
      logic [NONCE_W-1:0] nonce;
      logic [GATE_W-1:0]  gates;
      logic [REFS_W-1:0]  refs;
   } claim_entry_type;

   typedef struct packed {
      logic [NONCE_W-1:0] accessor;
      logic [NONCE_W-1:0] owner;
      logic [GATE_W-1:0]  gates;
   } auth_entry_type;

   typedef struct packed {
      logic [NONCE_W-1:0] owner;
      logic [GATE_W-1:0]  gates;
   } slot_entry_type;

endpackage
`default_nettype wire

// ----- design/gcat_if.sv -----
`default_nettype none
interface gcat_req_if;
   import gcat_pkg::*;
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     operation;
   logic [NONCE_W-1:0]  requester_id;
   logic [GATE_W-1:0]   gates;
   logic [HANDLE_W-1:0] handle;
   logic [HANDLE_W-1:0] token_handle;
   modport source (output valid, operation, requester_id, gates, handle, token_handle,
                   input ready);
   modport sink (input valid, operation, requester_id, gates, handle, token_handle,
                 output ready);
endinterface

interface gcat_rsp_if;
   import gcat_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ACTIVE_W-1:0] claims_active;
   modport source (output valid, status, claims_active, input ready);
   modport sink (input valid, status, claims_active, output ready);
endinterface

interface gcat_csr_if;
   import gcat_pkg::*;
   logic              valid;
   logic              ready;
   logic [GATE_W-1:0] valid_gate_mask;
   modport source (output valid, valid_gate_mask, input ready);
   modport sink (input valid, valid_gate_mask, output ready);
endinterface
`default_nettype wire

// ----- design/gcat_ram.sv -----
`default_nettype none
module gcat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

// ----- design/gcat_engine.sv -----
`default_nettype none
module gcat_engine (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire gcat_pkg::req_type         req_i,
   input  wire logic [gcat_pkg::GATE_W-1:0] vmask,
   output logic                           res_valid,
   input  wire logic                      res_ready,
   output gcat_pkg::rsp_type              res_o
);
   import gcat_pkg::*;

   state_type state_ff, state_in, route;
   req_type   req_ff, req_in;
   logic [CCNT_W-1:0]  p_ff, p_in;
   logic [ACNT_W-1:0]  a_ff, a_in;
   logic [CIDX_W-1:0]  e_ff, e_in;
   logic [AIDX_W-1:0]  afree_ff, afree_in;
   logic [NONCE_W-1:0] key_ff, key_in;
   logic [NONCE_W-1:0] owner_ff, owner_in;
   logic               find_ff, find_in;
   status_type         status_ff, status_in;
   logic [CCNT_W-1:0]  count_ff, count_in;
   logic [CLAIM_ENTRIES-1:0] cvalid_ff, cvalid_in;
   logic [CIDX_W-1:0]  order_ff [CLAIM_ENTRIES];
   logic [CIDX_W-1:0]  order_in [CLAIM_ENTRIES];
   logic [AUTH_ENTRIES-1:0] avalid_ff, avalid_in;
   logic [SIDX_W-1:0]  aslot_ff [AUTH_ENTRIES];
   logic [SIDX_W-1:0]  aslot_in [AUTH_ENTRIES];
   logic [HANDLE_SLOTS-1:0] active_ff, active_in, token_ff, token_in;

   // memory ports
   logic            c_we, a_we, s_we;
   logic [CIDX_W-1:0] c_waddr, c_raddr;
   logic [AIDX_W-1:0] a_waddr, a_raddr;
   logic [SIDX_W-1:0] s_waddr, s_raddr;
   claim_entry_type c_wdata, c_rdata;
   auth_entry_type  a_wdata, a_rdata;
   slot_entry_type  s_wdata, s_rdata;

   // request decode
   logic [GATE_W-1:0] g_i, g_ff;
   logic [SIDX_W-1:0] h_i, t_i, h_ff, t_ff;
   logic              hok_i, tok_i;
   logic [CIDX_W-1:0] cfree;
   logic              cfree_ok;
   logic [AIDX_W-1:0] afree;
   logic              afree_ok;
   logic [CIDX_W-1:0] pidx;
   logic              hit, amatch;
   logic [REFS_W-1:0] refs_dec;

   assign g_i   = req_i.gates & GMASK;
   assign h_i   = SIDX_W'(req_i.handle);
   assign t_i   = SIDX_W'(req_i.token_handle);
   assign hok_i = 32'(req_i.handle) < 32'(HANDLE_SLOTS);
   assign tok_i = 32'(req_i.token_handle) < 32'(HANDLE_SLOTS);
   assign g_ff  = req_ff.gates & GMASK;
   assign h_ff  = SIDX_W'(req_ff.handle);
   assign t_ff  = SIDX_W'(req_ff.token_handle);
   assign pidx  = p_ff[CIDX_W-1:0];

   // lowest free entries
   always_comb begin
      cfree    = '0;
      cfree_ok = 1'b0;
      for (int i = CLAIM_ENTRIES - 1; i >= 0; i--) begin
         if (!cvalid_ff[i]) begin
            cfree    = CIDX_W'(i);
            cfree_ok = 1'b1;
         end
      end
      afree    = '0;
      afree_ok = 1'b0;
      for (int i = AUTH_ENTRIES - 1; i >= 0; i--) begin
         if (!avalid_ff[i]) begin
            afree    = AIDX_W'(i);
            afree_ok = 1'b1;
         end
      end
   end

   assign hit = cvalid_ff[e_ff] &&
                (find_ff ? (c_rdata.nonce == key_ff) : ((c_rdata.gates & g_ff) != '0));
   assign amatch = avalid_ff[a_ff[AIDX_W-1:0]] && (a_rdata.accessor == req_ff.requester_id)
                   && (a_rdata.owner == owner_ff) && ((a_rdata.gates & g_ff) != '0);
   assign refs_dec = (c_rdata.refs != '0) ? c_rdata.refs - REFS_W'(1) : '0;

   // datapath and routing
   always_comb begin
      route     = state_ff;
      req_in    = req_ff;
      p_in      = p_ff;
      a_in      = a_ff;
      e_in      = e_ff;
      afree_in  = afree_ff;
      key_in    = key_ff;
      owner_in  = owner_ff;
      find_in   = find_ff;
      status_in = status_ff;
      count_in  = count_ff;
      cvalid_in = cvalid_ff;
      order_in  = order_ff;
      avalid_in = avalid_ff;
      aslot_in  = aslot_ff;
      active_in = active_ff;
      token_in  = token_ff;
      c_we = 1'b0; c_waddr = e_ff; c_wdata = c_rdata; c_raddr = order_ff[pidx];
      a_we = 1'b0; a_waddr = afree_ff; a_wdata = a_rdata; a_raddr = a_ff[AIDX_W-1:0];
      s_we = 1'b0; s_waddr = h_ff; s_wdata = s_rdata; s_raddr = h_ff;

      unique case (state_ff)
         S_IDLE: begin
            req_in  = req_i;
            p_in    = '0;
            a_in    = '0;
            key_in  = req_i.requester_id;
            find_in = 1'b1;
            route   = S_DONE;
            status_in = ST_OK;
            if (req_valid) begin
               if (req_i.operation == OP_CHECK) begin
                  find_in = 1'b0;
                  route   = S_CLM_RD;
               end else if (req_i.operation == OP_REVOKE) begin
                  if (!hok_i) begin
                     status_in = ST_INVALID;
                  end else begin
                     active_in[h_i] = 1'b0;
                     token_in[h_i]  = 1'b0;
                     if (active_ff[h_i] && token_ff[h_i]) begin
                        for (int i = 0; i < AUTH_ENTRIES; i++) begin
                           if (aslot_ff[i] == h_i) avalid_in[i] = 1'b0;
                        end
                     end else if (active_ff[h_i]) begin
                        route = S_SLOT_RD;
                     end
                  end
               end else if (req_i.requester_id == '0) begin
                  status_in = ST_NOID;
               end else if (req_i.operation > OP_REVOKE) begin
                  status_in = ST_UNSUP;
               end else if (!hok_i) begin
                  status_in = ST_INVALID;
               end else begin
                  unique case (req_i.operation)
                     OP_CLAIM: begin
                        if (g_i == '0 || (g_i & ~(vmask & GMASK)) != '0)
                           status_in = ST_INVALID;
                        else if (active_ff[h_i])
                           status_in = ST_OK;
                        else if (token_ff[h_i])
                           status_in = ST_INVALID;
                        else
                           route = S_CLM_RD;
                     end
                     OP_RELEASE: begin
                        if (!active_ff[h_i] || token_ff[h_i]) begin
                           status_in = ST_INVALID;
                        end else begin
                           active_in[h_i] = 1'b0;
                           route = S_SLOT_RD;
                        end
                     end
                     OP_MINT: begin
                        if (token_ff[h_i] || !active_ff[h_i] || !tok_i)
                           status_in = ST_INVALID;
                        else if (active_ff[t_i])
                           status_in = ST_FULL;
                        else
                           route = S_SLOT_RD;
                     end
                     default: begin
                        // authorize
                        if (!token_ff[h_i]) begin
                           status_in = ST_INVALID;
                        end else if (active_ff[h_i]) begin
                           status_in = ST_OK;
                        end else if (!afree_ok) begin
                           status_in = ST_FULL;
                        end else begin
                           afree_in = afree;
                           route = S_SLOT_RD;
                        end
                     end
                  endcase
               end
            end
         end
         S_SLOT_RD: begin
            route = S_SLOT_EV;
         end
         S_SLOT_EV: begin
            route = S_DONE;
            status_in = ST_OK;
            if (req_ff.operation == OP_MINT) begin
               s_we = 1'b1;
               s_waddr = t_ff;
               s_wdata = s_rdata;
               token_in[t_ff]  = 1'b1;
               active_in[t_ff] = 1'b0;
            end else if (req_ff.operation == OP_AUTHORIZE) begin
               a_we = 1'b1;
               a_wdata = '{accessor: req_ff.requester_id, owner: s_rdata.owner,
                           gates: s_rdata.gates};
               avalid_in[afree_ff] = 1'b1;
               aslot_in[afree_ff]  = h_ff;
               active_in[h_ff]     = 1'b1;
            end else begin
               // release or revoke: drop the owner's claim reference
               key_in = s_rdata.owner;
               route  = S_CLM_RD;
            end
         end
         S_CLM_RD: begin
            if (p_ff >= count_ff) begin
               route = S_DONE;
               status_in = ST_OK;
               if (find_ff && req_ff.operation == OP_CLAIM) begin
                  if (count_ff >= CCNT_W'(CLAIM_ENTRIES) || !cfree_ok) begin
                     status_in = ST_FULL;
                  end else begin
                     c_we = 1'b1;
                     c_waddr = cfree;
                     c_wdata = '{nonce: req_ff.requester_id, gates: g_ff, refs: REFS_W'(1)};
                     cvalid_in[cfree] = 1'b1;
                     order_in[0] = cfree;
                     for (int i = 1; i < CLAIM_ENTRIES; i++) order_in[i] = order_ff[i-1];
                     count_in = count_ff + CCNT_W'(1);
                     s_we = 1'b1;
                     s_wdata = '{owner: req_ff.requester_id, gates: g_ff};
                     active_in[h_ff] = 1'b1;
                  end
               end
            end else begin
               e_in  = order_ff[pidx];
               route = S_CLM_EV;
            end
         end
         S_CLM_EV: begin
            if (!hit) begin
               p_in  = p_ff + CCNT_W'(1);
               route = S_CLM_RD;
            end else if (!find_ff) begin
               route = S_DONE;
               if (req_ff.requester_id != '0 && req_ff.requester_id == c_rdata.nonce) begin
                  status_in = ST_OK;
               end else if (req_ff.requester_id == '0) begin
                  status_in = ST_DENIED;
               end else begin
                  owner_in = c_rdata.nonce;
                  route = S_AUTH_RD;
               end
            end else if (req_ff.operation == OP_CLAIM) begin
               route = S_DONE;
               status_in = ST_OK;
               c_we = 1'b1;
               c_wdata = '{nonce: c_rdata.nonce, gates: c_rdata.gates | g_ff,
                           refs: (c_rdata.refs < REFS_MAX) ? c_rdata.refs + REFS_W'(1)
                                                           : c_rdata.refs};
               s_we = 1'b1;
               s_wdata = '{owner: req_ff.requester_id, gates: g_ff};
               active_in[h_ff] = 1'b1;
            end else begin
               route = S_DONE;
               status_in = ST_OK;
               if (refs_dec != '0) begin
                  c_we = 1'b1;
                  c_wdata = '{nonce: c_rdata.nonce, gates: c_rdata.gates, refs: refs_dec};
               end else begin
                  cvalid_in[e_ff] = 1'b0;
                  for (int i = 0; i < CLAIM_ENTRIES - 1; i++) begin
                     if (CCNT_W'(i) >= p_ff) order_in[i] = order_ff[i+1];
                  end
                  count_in = count_ff - CCNT_W'(1);
               end
            end
         end
         S_AUTH_RD: begin
            if (a_ff >= ACNT_W'(AUTH_ENTRIES)) begin
               route = S_DONE;
               status_in = ST_DENIED;
            end else begin
               route = S_AUTH_EV;
            end
         end
         S_AUTH_EV: begin
            if (amatch) begin
               route = S_DONE;
               status_in = ST_OK;
            end else begin
               a_in  = a_ff + ACNT_W'(1);
               route = S_AUTH_RD;
            end
         end
         S_DONE: begin
            route = S_IDLE;
         end
         default: begin
            route = S_IDLE;
         end
      endcase
   end

   // next state
   always_comb begin
      unique case (state_ff)
         S_IDLE:  state_in = req_valid ? route : S_IDLE;
         S_DONE:  state_in = res_ready ? S_IDLE : S_DONE;
         default: state_in = route;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = (state_ff == S_IDLE);
      res_valid = (state_ff == S_DONE);
      res_o.status = status_ff;
      res_o.claims_active = ACTIVE_W'(count_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         cvalid_ff <= '0;
         avalid_ff <= '0;
         active_ff <= '0;
         token_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         cvalid_ff <= cvalid_in;
         avalid_ff <= avalid_in;
         active_ff <= active_in;
         token_ff  <= token_in;
      end
      req_ff    <= req_in;
      p_ff      <= p_in;
      a_ff      <= a_in;
      e_ff      <= e_in;
      afree_ff  <= afree_in;
      key_ff    <= key_in;
      owner_ff  <= owner_in;
      find_ff   <= find_in;
      status_ff <= status_in;
      order_ff  <= order_in;
      aslot_ff  <= aslot_in;
   end

   gcat_ram #(.WIDTH($bits(claim_entry_type)), .DEPTH(CLAIM_ENTRIES)) u_claim_ram (
      .clock (clock), .we (c_we), .waddr (c_waddr), .wdata (c_wdata),
      .raddr (c_raddr), .rdata (c_rdata)
   );

   gcat_ram #(.WIDTH($bits(auth_entry_type)), .DEPTH(AUTH_ENTRIES)) u_auth_ram (
      .clock (clock), .we (a_we), .waddr (a_waddr), .wdata (a_wdata),
      .raddr (a_raddr), .rdata (a_rdata)
   );

   gcat_ram #(.WIDTH($bits(slot_entry_type)), .DEPTH(HANDLE_SLOTS)) u_slot_ram (
      .clock (clock), .we (s_we), .waddr (s_waddr), .wdata (s_wdata),
      .raddr (s_raddr), .rdata (s_rdata)
   );

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CCNT_W'(CLAIM_ENTRIES))
      else $error("claim count beyond store size");

   a_count_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(cvalid_ff) == int'(count_ff))
      else $error("claim count disagrees with live entries");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != S_IDLE))
      else $error("engine idle right after accepting a request");
`endif
endmodule
`default_nettype wire

// ----- design/gate_claim_authorization_table.sv -----
// Channel | Dir | Handshake     | Payload
// req_ch  | in  | valid/ready   | operation, requester_id, gates, handle, token_handle
// rsp_ch  | out | valid/ready   | status, claims_active
// csr_ch  | in  | valid/ready   | valid_gate_mask (always ready)
//
// One request at a time. Checks and claim lookups walk the newest-first claim
// list entry by entry (claim RAM read, then compare); a check that hits a
// foreign claim then walks the authorization RAM entry by entry. Reset
// (synchronous, active high) clears valid bits, count and handle flags; RAM
// contents need no clearing. The response register lets the engine take the
// next request while a response waits on rsp_ch.ready.
`default_nettype none
module gate_claim_authorization_table (
   input  wire logic clock,
   input  wire logic reset,
   gcat_req_if.sink   req_ch,
   gcat_rsp_if.source rsp_ch,
   gcat_csr_if.sink   csr_ch
);
   import gcat_pkg::*;

   logic [GATE_W-1:0] vmask_ff, vmask_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   req_type           req_bus;
   rsp_type           res_bus;
   logic              res_valid, res_ready, eng_ready;

   // config register: writes must arrive only while idle; the block does not enforce this
   assign csr_ch.ready = 1'b1;
   assign vmask_in = csr_ch.valid ? csr_ch.valid_gate_mask : vmask_ff;

   assign req_bus.operation    = req_ch.operation;
   assign req_bus.requester_id = req_ch.requester_id;
   assign req_bus.gates        = req_ch.gates;
   assign req_bus.handle       = req_ch.handle;
   assign req_bus.token_handle = req_ch.token_handle;
   assign req_ch.ready         = eng_ready;

   gcat_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (eng_ready),
      .req_i     (req_bus),
      .vmask     (vmask_ff),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_o     (res_bus)
   );

   // response register
   assign res_ready    = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_valid_in = (res_valid && res_ready) || (rsp_valid_ff && !rsp_ch.ready);
   assign rsp_data_in  = (res_valid && res_ready) ? res_bus : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vmask_ff     <= VMASK_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         vmask_ff     <= vmask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_data_ff.status;
   assign rsp_ch.claims_active = rsp_data_ff.claims_active;
endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
   import gcat_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #1 clock = ~clock;

   gcat_req_if req_ch ();
   gcat_rsp_if rsp_ch ();
   gcat_csr_if csr_ch ();

   gate_claim_authorization_table u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   // ---------------------------------------------------------------
   // Shadow of the gate engine state
   // ---------------------------------------------------------------
   logic [GATE_W-1:0]  gate_mask_q;
   logic               cl_live   [CLAIM_ENTRIES];
   logic [NONCE_W-1:0] cl_nonce  [CLAIM_ENTRIES];
   logic [GATE_W-1:0]  cl_gates  [CLAIM_ENTRIES];
   logic [REFS_W-1:0]  cl_refs   [CLAIM_ENTRIES];
   int                 cl_order  [CLAIM_ENTRIES];
   int                 cl_count;
   logic               au_live   [AUTH_ENTRIES];
   logic [NONCE_W-1:0] au_accessor [AUTH_ENTRIES];
   logic [NONCE_W-1:0] au_owner  [AUTH_ENTRIES];
   logic [GATE_W-1:0]  au_gates  [AUTH_ENTRIES];
   int                 au_slot   [AUTH_ENTRIES];
   logic               hs_active [HANDLE_SLOTS];
   logic               hs_token  [HANDLE_SLOTS];
   logic [NONCE_W-1:0] hs_owner  [HANDLE_SLOTS];
   logic [GATE_W-1:0]  hs_gates  [HANDLE_SLOTS];

   rsp_type expected_rsp_q[$];
   int      error_count = 0;
   int      rsp_seen = 0;
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;

   function automatic void clear_shadow();
      gate_mask_q = VMASK_RESET;
      cl_count = 0;
      for (int i = 0; i < CLAIM_ENTRIES; i++) begin
         cl_live[i] = 1'b0; cl_nonce[i] = '0; cl_gates[i] = '0;
         cl_refs[i] = '0; cl_order[i] = 0;
      end
      for (int i = 0; i < AUTH_ENTRIES; i++) begin
         au_live[i] = 1'b0; au_accessor[i] = '0; au_owner[i] = '0;
         au_gates[i] = '0; au_slot[i] = 0;
      end
      for (int i = 0; i < HANDLE_SLOTS; i++) begin
         hs_active[i] = 1'b0; hs_token[i] = 1'b0;
         hs_owner[i] = '0; hs_gates[i] = '0;
      end
   endfunction

   // position in the newest-first list, or -1
   function automatic int claim_pos(logic [NONCE_W-1:0] n);
      for (int p = 0; p < cl_count; p++)
         if (cl_live[cl_order[p]] && cl_nonce[cl_order[p]] == n) return p;
      return -1;
   endfunction

   function automatic void drop_ref(logic [NONCE_W-1:0] owner);
      int p;
      int e;
      p = claim_pos(owner);
      if (p < 0) return;
      e = cl_order[p];
      if (cl_refs[e] != 0) cl_refs[e]--;
      if (cl_refs[e] != 0) return;
      cl_live[e] = 1'b0;
      for (; p + 1 < cl_count; p++) cl_order[p] = cl_order[p+1];
      if (cl_count > 0) cl_count--;
   endfunction

   function automatic status_type gate_check(logic [NONCE_W-1:0] n, logic [GATE_W-1:0] g);
      int e;
      for (int p = 0; p < cl_count; p++) begin
         e = cl_order[p];
         if (!cl_live[e] || (cl_gates[e] & g) == '0) continue;
         if (n != '0 && n == cl_nonce[e]) return ST_OK;
         if (n == '0) return ST_DENIED;
         for (int a = 0; a < AUTH_ENTRIES; a++)
            if (au_live[a] && au_accessor[a] == n && au_owner[a] == cl_nonce[e]
                && (au_gates[a] & g) != '0) return ST_OK;
         return ST_DENIED;
      end
      return ST_OK;
   endfunction

   function automatic status_type gate_claim(logic [NONCE_W-1:0] n, logic [GATE_W-1:0] g,
                                             int h);
      int p;
      int e;
      if (g == '0 || (g & ~(gate_mask_q & GMASK)) != '0) return ST_INVALID;
      if (hs_token[h] || hs_active[h]) return hs_active[h] ? ST_OK : ST_INVALID;
      p = claim_pos(n);
      if (p >= 0) begin
         e = cl_order[p];
         cl_gates[e] |= g;
         if (cl_refs[e] < REFS_MAX) cl_refs[e]++;
      end else begin
         if (cl_count >= CLAIM_ENTRIES) return ST_FULL;
         for (e = 0; e < CLAIM_ENTRIES; e++) if (!cl_live[e]) break;
         if (e >= CLAIM_ENTRIES) return ST_FULL;
         cl_live[e] = 1'b1; cl_nonce[e] = n; cl_gates[e] = g; cl_refs[e] = 1;
         for (int q = cl_count; q > 0; q--) cl_order[q] = cl_order[q-1];
         cl_order[0] = e;
         cl_count++;
      end
      hs_gates[h] = g; hs_owner[h] = n; hs_active[h] = 1'b1;
      return ST_OK;
   endfunction

   function automatic status_type gate_authorize(logic [NONCE_W-1:0] n, int h);
      int a;
      if (!hs_token[h]) return ST_INVALID;
      if (hs_active[h]) return ST_OK;
      for (a = 0; a < AUTH_ENTRIES; a++) if (!au_live[a]) break;
      if (a >= AUTH_ENTRIES) return ST_FULL;
      au_live[a] = 1'b1; au_accessor[a] = n; au_owner[a] = hs_owner[h];
      au_gates[a] = hs_gates[h]; au_slot[a] = h;
      hs_active[h] = 1'b1;
      return ST_OK;
   endfunction

   function automatic void gate_revoke(int h);
      if (hs_active[h]) begin
         if (hs_token[h]) begin
            for (int a = 0; a < AUTH_ENTRIES; a++)
               if (au_live[a] && au_slot[a] == h) au_live[a] = 1'b0;
         end else begin
            drop_ref(hs_owner[h]);
         end
      end
      hs_active[h] = 1'b0; hs_token[h] = 1'b0; hs_owner[h] = '0; hs_gates[h] = '0;
   endfunction

   // Advance the shadow by one request and return the response it should give.
   function automatic rsp_type predict_gate_rsp(req_type r);
      status_type st;
      rsp_type    o;
      int         h;
      int         t;
      h = r.handle;
      t = r.token_handle;
      if (r.operation == OP_CHECK) st = gate_check(r.requester_id, r.gates);
      else if (r.operation == OP_REVOKE) begin
         gate_revoke(h);
         st = ST_OK;
      end else if (r.requester_id == '0) st = ST_NOID;
      else if (r.operation > OP_REVOKE) st = ST_UNSUP;
      else if (r.operation == OP_CLAIM) st = gate_claim(r.requester_id, r.gates, h);
      else if (r.operation == OP_RELEASE) begin
         if (!hs_active[h] || hs_token[h]) st = ST_INVALID;
         else begin
            drop_ref(hs_owner[h]);
            hs_active[h] = 1'b0;
            st = ST_OK;
         end
      end else if (r.operation == OP_MINT) begin
         if (hs_token[h] || !hs_active[h]) st = ST_INVALID;
         else if (hs_active[t]) st = ST_FULL;
         else begin
            hs_token[t] = 1'b1; hs_active[t] = 1'b0;
            hs_owner[t] = hs_owner[h]; hs_gates[t] = hs_gates[h];
            st = ST_OK;
         end
      end else st = gate_authorize(r.requester_id, h);
      o.status = st;
      o.claims_active = ACTIVE_W'(cl_count);
      return o;
   endfunction

   // ---------------------------------------------------------------
   // Driving: after the initial values, all inputs change by nonblocking assignment at posedge
   // ---------------------------------------------------------------
   initial begin
      req_ch.valid = 1'b0; req_ch.operation = '0; req_ch.requester_id = '0;
      req_ch.gates = '0; req_ch.handle = '0; req_ch.token_handle = '0;
      csr_ch.valid = 1'b0; csr_ch.valid_gate_mask = '0;
   end

   // Sends one request, with a random idle gap ahead of it; valid stays up
   // between back-to-back requests.
   task automatic send_request(req_type r);
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_ch.valid        <= 1'b1;
      req_ch.operation    <= r.operation;
      req_ch.requester_id <= r.requester_id;
      req_ch.gates        <= r.gates;
      req_ch.handle       <= r.handle;
      req_ch.token_handle <= r.token_handle;
      do @(posedge clock); while (!req_ch.ready);
      // accepted at this edge: predict in request order
      expected_rsp_q.push_back(predict_gate_rsp(r));
   endtask

   // Writes the mask register; only called with nothing outstanding.
   task automatic write_gate_mask(logic [GATE_W-1:0] m);
      csr_ch.valid           <= 1'b1;
      csr_ch.valid_gate_mask <= m;
      do @(posedge clock); while (!csr_ch.ready);
      gate_mask_q = m;
      csr_ch.valid <= 1'b0;
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      req_ch.valid <= 1'b0;
      while (expected_rsp_q.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (100) @(posedge clock);
   endtask

   // Receiver: random stall, compare at the accepting edge.
   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         rsp_seen++;
         if (expected_rsp_q.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("ERROR: response with none pending: status %0d active %0d",
                        rsp_ch.status, rsp_ch.claims_active);
         end else begin
            exp_r = expected_rsp_q.pop_front();
            if (rsp_ch.status !== exp_r.status
                || rsp_ch.claims_active !== exp_r.claims_active) begin
               error_count++;
               if (error_count <= 10)
                  $display("ERROR: response %0d: exp status %0d active %0d, got %0d %0d",
                           rsp_seen, exp_r.status, exp_r.claims_active,
                           rsp_ch.status, rsp_ch.claims_active);
            end
         end
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Random request biased toward well-formed sequences over a small set of
   // nonces and handles so claims, tokens and authorizations pile up.
   function automatic req_type random_request();
      req_type r;
      int      k;
      r.operation    = $urandom_range(99) < 4 ? 3'($urandom_range(7)) :
                       3'($urandom_range(5));
      k = $urandom_range(99);
      if (k < 5) r.requester_id = '0;
      else if (k < 10) r.requester_id = {$urandom, $urandom};
      else r.requester_id = 64'($urandom_range(6)) + 64'h1
                            + (k < 40 ? 64'hFFFF_0000_0000_0000 : 64'h0);
      k = $urandom_range(99);
      if (k < 60) r.gates = GATE_W'(1) << $urandom_range(GATE_W - 1);
      else if (k < 90) r.gates = GATE_W'($urandom_range(7) << $urandom_range(GATE_W - 1));
      else r.gates = GATE_W'($urandom);
      r.handle       = $urandom_range(99) < 80 ? 4'($urandom_range(5)) : 4'($urandom);
      r.token_handle = $urandom_range(99) < 80 ? 4'($urandom_range(5)) : 4'($urandom);
      return r;
   endfunction

   // Directed table; expected status typed in where obvious, else 7 = predict.
   typedef struct {
      req_type    r;
      logic [2:0] st;
   } dir_row_type;
   localparam logic [2:0] PREDICT = 3'd7;
   localparam logic [NONCE_W-1:0] NA = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [NONCE_W-1:0] NB = 64'h0000_0000_0000_0001;

   dir_row_type dir_rows[$];

   function automatic void add_row(logic [2:0] op, logic [NONCE_W-1:0] n,
                                   logic [GATE_W-1:0] g, logic [3:0] h,
                                   logic [3:0] t, logic [2:0] st);
      dir_row_type d;
      d.r.operation = op; d.r.requester_id = n; d.r.gates = g;
      d.r.handle = h; d.r.token_handle = t; d.st = st;
      dir_rows.push_back(d);
   endfunction

   initial begin
      rsp_type exp_r;
      int      phase_items;
      clear_shadow();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // check on an empty table always allows
      add_row(OP_CHECK,     '0, 11'h7FF, 4'd0,  4'd0,  ST_OK);
      add_row(OP_CLAIM,     '0, 11'h001, 4'd0,  4'd0,  ST_NOID);
      add_row(OP_RSVD_6,    NA, 11'h001, 4'd0,  4'd0,  ST_UNSUP);
      add_row(OP_RSVD_7,    NA, 11'h001, 4'd15, 4'd15, ST_UNSUP);
      add_row(OP_CLAIM,     NA, 11'h000, 4'd0,  4'd0,  ST_INVALID);
      add_row(OP_RELEASE,   NA, 11'h000, 4'd15, 4'd0,  ST_INVALID);
      add_row(OP_CLAIM,     NA, 11'h7FF, 4'd15, 4'd0,  PREDICT);
      add_row(OP_CLAIM,     NA, 11'h400, 4'd15, 4'd0,  PREDICT); // active slot
      add_row(OP_CHECK,     NB, 11'h400, 4'd0,  4'd0,  ST_DENIED);
      add_row(OP_CHECK,     '0, 11'h001, 4'd0,  4'd0,  ST_DENIED);
      add_row(OP_CHECK,     NA, 11'h001, 4'd0,  4'd0,  PREDICT);
      add_row(OP_MINT,      NA, 11'h000, 4'd15, 4'd15, ST_FULL); // into itself
      add_row(OP_MINT,      NA, 11'h000, 4'd15, 4'd3,  PREDICT);
      add_row(OP_MINT,      NA, 11'h000, 4'd3,  4'd4,  ST_INVALID);
      add_row(OP_CLAIM,     NB, 11'h001, 4'd3,  4'd0,  ST_INVALID); // token slot
      add_row(OP_AUTHORIZE, NB, 11'h000, 4'd0,  4'd0,  ST_INVALID);
      add_row(OP_AUTHORIZE, NB, 11'h000, 4'd3,  4'd0,  PREDICT);
      add_row(OP_AUTHORIZE, NB, 11'h000, 4'd3,  4'd0,  PREDICT); // already active
      add_row(OP_CHECK,     NB, 11'h010, 4'd0,  4'd0,  PREDICT);
      add_row(OP_CHECK,     NB, 11'h000, 4'd0,  4'd0,  ST_OK);   // zero gate
      add_row(OP_REVOKE,    '0, 11'h000, 4'd3,  4'd0,  ST_OK);
      add_row(OP_CHECK,     NB, 11'h010, 4'd0,  4'd0,  ST_DENIED);
      add_row(OP_RELEASE,   NA, 11'h000, 4'd15, 4'd0,  PREDICT);
      add_row(OP_REVOKE,    NA, 11'h000, 4'd15, 4'd0,  ST_OK);

      foreach (dir_rows[i]) begin
         send_request(dir_rows[i].r);
         exp_r = expected_rsp_q[$];
         if (dir_rows[i].st != PREDICT && exp_r.status != dir_rows[i].st) begin
            error_count++;
            if (error_count <= 10)
               $display("ERROR: directed row %0d: table status %0d, predicted %0d",
                        i, dir_rows[i].st, exp_r.status);
         end
      end
      drain();

      // Random phases across idling patterns and mask settings, extremes first.
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
            default: begin send_idle_pct = 28; recv_stall_pct = 28; end
         endcase
         case (ph)
            0: write_gate_mask('0);
            1: write_gate_mask('1);
            2: write_gate_mask(11'h0FF);
            default: write_gate_mask(GATE_W'($urandom));
         endcase
         phase_items = 50;
         for (int i = 0; i < phase_items; i++) send_request(random_request());
         drain();
      end

      if (error_count == 0 && expected_rsp_q.size() == 0)
         $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

   initial begin
      #2000000;
      $display("Test completed with failures");
      $finish;
   end
endmodule
